FILE: src/pps_pkg.sv
`timescale 1ns / 1ps

package pps_pkg;

   localparam int SLOTS       = 16;
   localparam int TIME_BITS   = 16;
   localparam int ID_BITS     = 8;
   localparam int PRIO_BITS   = 8;
   localparam int BURST_BITS  = 16;
   localparam int SLOT_BITS   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_FIELD_BITS = ID_BITS + PRIO_BITS + BURST_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = ID_BITS + 3 * TIME_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int STATUS_BITS    = 3;

   typedef logic [SLOT_BITS-1:0]   slot_idx_type;
   typedef logic [TIME_BITS-1:0]   time_type;
   typedef logic [ID_BITS-1:0]     id_type;
   typedef logic [PRIO_BITS-1:0]   prio_type;
   typedef logic [BURST_BITS-1:0]  burst_type;
   typedef logic [QUEUE_BITS-1:0]  qptr_type;
   typedef logic [QCOUNT_BITS-1:0] qcount_type;

   typedef enum logic {
      CMD_ADD  = 1'b0,
      CMD_TICK = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_ADDED     = 3'd0,
      ST_FULL      = 3'd1,
      ST_IDLE_TICK = 3'd2,
      ST_RAN       = 3'd3,
      ST_COMPLETED = 3'd4
   } status_type;

   typedef struct packed {
      cmd_type   cmd;
      id_type    job_id;
      prio_type  job_priority;
      burst_type job_burst;
   } job_item_type;

   function automatic time_type time_inc(input time_type t);
      return (t == '1) ? t : time_type'(t + time_type'(1));
   endfunction

endpackage

FILE: src/pps_front.sv
`timescale 1ns / 1ps

module pps_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pps_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                              req_tuser,
   output logic                              q_valid,
   input  logic                              q_ready,
   output pps_pkg::job_item_type             q_item
);

   pps_pkg::job_item_type queue_ff [pps_pkg::QUEUE_DEPTH];
   pps_pkg::qptr_type     wr_ptr_ff, wr_ptr_in;
   pps_pkg::qptr_type     rd_ptr_ff, rd_ptr_in;
   pps_pkg::qcount_type   count_ff, count_in;
   pps_pkg::job_item_type item_in;
   logic                  push, pop;

   function automatic pps_pkg::qptr_type ptr_next(input pps_pkg::qptr_type p);
      return (p == pps_pkg::qptr_type'(pps_pkg::QUEUE_DEPTH - 1)) ?
             '0 : pps_pkg::qptr_type'(p + pps_pkg::qptr_type'(1));
   endfunction

   // classify: tuser carries the command, tdata the job fields
   always_comb begin
      item_in.cmd          = req_tuser ? pps_pkg::CMD_TICK : pps_pkg::CMD_ADD;
      item_in.job_id       = req_tdata[pps_pkg::ID_BITS-1:0];
      item_in.job_priority = req_tdata[pps_pkg::ID_BITS +: pps_pkg::PRIO_BITS];
      item_in.job_burst    =
         req_tdata[pps_pkg::ID_BITS + pps_pkg::PRIO_BITS +: pps_pkg::BURST_BITS];
   end

   assign req_tready = (count_ff != pps_pkg::qcount_type'(pps_pkg::QUEUE_DEPTH));
   assign q_valid    = (count_ff != '0);
   assign q_item     = queue_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = pps_pkg::qcount_type'(count_ff + pps_pkg::qcount_type'(1));
      end else if (pop && !push) begin
         count_in = pps_pkg::qcount_type'(count_ff - pps_pkg::qcount_type'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

FILE: src/pps_back.sv
`timescale 1ns / 1ps

module pps_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   output logic                              q_ready,
   input  pps_pkg::job_item_type             q_item,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pps_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic [pps_pkg::STATUS_BITS-1:0]   rsp_tuser
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_EXEC = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // slot table
   logic                   valid_ff [pps_pkg::SLOTS];
   pps_pkg::id_type        id_ff    [pps_pkg::SLOTS];
   pps_pkg::prio_type      prio_ff  [pps_pkg::SLOTS];
   pps_pkg::burst_type     rem_ff   [pps_pkg::SLOTS];
   pps_pkg::burst_type     burst_ff [pps_pkg::SLOTS];
   pps_pkg::time_type      arr_ff   [pps_pkg::SLOTS];
   pps_pkg::time_type      start_ff [pps_pkg::SLOTS];

   pps_pkg::time_type      now_ff;
   pps_pkg::slot_idx_type  scan_idx_ff;

   // best candidate so far
   logic                   best_found_ff;
   pps_pkg::slot_idx_type  best_idx_ff;
   pps_pkg::id_type        best_id_ff;
   pps_pkg::prio_type      best_prio_ff;
   pps_pkg::burst_type     best_rem_ff;
   pps_pkg::burst_type     best_burst_ff;
   pps_pkg::time_type      best_arr_ff;
   pps_pkg::time_type      best_start_ff;

   // result register
   logic                   rsp_valid_ff;
   pps_pkg::status_type    rsp_status_ff;
   pps_pkg::id_type        rsp_id_ff;
   pps_pkg::time_type      rsp_start_ff;
   pps_pkg::time_type      rsp_finish_ff;
   pps_pkg::time_type      rsp_turn_ff;

   logic                   out_free;
   logic                   do_add, do_tick, do_exec;
   logic                   free_found;
   pps_pkg::slot_idx_type  free_idx;
   logic                   cand_better;
   logic                   first_run, complete;
   pps_pkg::time_type      start_val, finish_val, turn_val;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign q_ready  = (state_ff == S_IDLE) && q_valid &&
                     ((q_item.cmd == pps_pkg::CMD_TICK) || out_free);
   assign do_add   = q_valid && q_ready && (q_item.cmd == pps_pkg::CMD_ADD);
   assign do_tick  = q_valid && q_ready && (q_item.cmd == pps_pkg::CMD_TICK);
   assign do_exec  = (state_ff == S_EXEC) && out_free;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = pps_pkg::SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = pps_pkg::slot_idx_type'(i);
         end
      end
   end

   // strict compare keeps the lower slot on a full tie
   assign cand_better = valid_ff[scan_idx_ff] &&
      (!best_found_ff ||
       ({prio_ff[scan_idx_ff], arr_ff[scan_idx_ff], id_ff[scan_idx_ff]} <
        {best_prio_ff, best_arr_ff, best_id_ff}));

   assign first_run  = (best_rem_ff == best_burst_ff);
   assign complete   = (best_rem_ff <= pps_pkg::burst_type'(1));
   assign start_val  = first_run ? now_ff : best_start_ff;
   assign finish_val = pps_pkg::time_inc(now_ff);
   assign turn_val   = pps_pkg::time_type'(finish_val - best_arr_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (do_tick) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (scan_idx_ff == pps_pkg::slot_idx_type'(pps_pkg::SLOTS - 1)) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (do_exec) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         now_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         best_found_ff <= 1'b0;
         scan_idx_ff   <= '0;
         for (int i = 0; i < pps_pkg::SLOTS; i++) valid_ff[i] <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (do_add || do_exec) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (do_tick) begin
            best_found_ff <= 1'b0;
            scan_idx_ff   <= '0;
         end else if (state_ff == S_SCAN) begin
            if (cand_better) best_found_ff <= 1'b1;
            scan_idx_ff <= pps_pkg::slot_idx_type'(scan_idx_ff +
                                                   pps_pkg::slot_idx_type'(1));
         end
         if (do_add && free_found) begin
            valid_ff[free_idx] <= 1'b1;
         end
         if (do_exec) begin
            now_ff <= finish_val;
            if (best_found_ff && complete) valid_ff[best_idx_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_add && free_found) begin
         id_ff[free_idx]    <= q_item.job_id;
         prio_ff[free_idx]  <= q_item.job_priority;
         burst_ff[free_idx] <= q_item.job_burst;
         rem_ff[free_idx]   <= q_item.job_burst;
         arr_ff[free_idx]   <= now_ff;
         start_ff[free_idx] <= '0;
      end
      if (do_exec && best_found_ff) begin
         start_ff[best_idx_ff] <= start_val;
         rem_ff[best_idx_ff]   <= complete ? '0 :
            pps_pkg::burst_type'(best_rem_ff - pps_pkg::burst_type'(1));
      end
      if (state_ff == S_SCAN && cand_better) begin
         best_idx_ff   <= scan_idx_ff;
         best_id_ff    <= id_ff[scan_idx_ff];
         best_prio_ff  <= prio_ff[scan_idx_ff];
         best_rem_ff   <= rem_ff[scan_idx_ff];
         best_burst_ff <= burst_ff[scan_idx_ff];
         best_arr_ff   <= arr_ff[scan_idx_ff];
         best_start_ff <= start_ff[scan_idx_ff];
      end
      if (do_add) begin
         rsp_status_ff <= free_found ? pps_pkg::ST_ADDED : pps_pkg::ST_FULL;
         rsp_id_ff     <= '0;
         rsp_start_ff  <= '0;
         rsp_finish_ff <= '0;
         rsp_turn_ff   <= '0;
      end else if (do_exec) begin
         rsp_id_ff <= best_found_ff ? best_id_ff : '0;
         if (!best_found_ff) begin
            rsp_status_ff <= pps_pkg::ST_IDLE_TICK;
            rsp_start_ff  <= '0;
            rsp_finish_ff <= '0;
            rsp_turn_ff   <= '0;
         end else if (complete) begin
            rsp_status_ff <= pps_pkg::ST_COMPLETED;
            rsp_start_ff  <= start_val;
            rsp_finish_ff <= finish_val;
            rsp_turn_ff   <= turn_val;
         end else begin
            rsp_status_ff <= pps_pkg::ST_RAN;
            rsp_start_ff  <= '0;
            rsp_finish_ff <= '0;
            rsp_turn_ff   <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = pps_pkg::RSP_DATA_BITS'({rsp_turn_ff, rsp_finish_ff,
                                               rsp_start_ff, rsp_id_ff});

endmodule

FILE: src/preemptive_priority_scheduler.sv
// Add: the job passes through the queue entry and then the result register; one add
//   per cycle sustained while results are taken and no tick is in progress. Tick: the back
//   end walks the slot table with a single comparator, then issues the result in S_EXEC.
// A 2-entry queue decouples input from execution; the result register frees the back end.
// Reset (synchronous, active high) empties the queue and slot table and clears time to 0.
`timescale 1ns / 1ps

module preemptive_priority_scheduler (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // job_id, job_priority, job_burst
   input  logic [pps_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // cmd
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // done_id, start_time, finish_time, turnaround
   output logic [pps_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // status
   output logic [pps_pkg::STATUS_BITS-1:0]   rsp_tuser
);

   logic                  q_valid;
   logic                  q_ready;
   pps_pkg::job_item_type q_item;

   pps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_item     (q_item)
   );

   pps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_item     (q_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: src/pps_checker.sv
`timescale 1ns / 1ps

module pps_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [pps_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic [pps_pkg::STATUS_BITS-1:0]   rsp_tuser
);

   localparam int TB = pps_pkg::TIME_BITS;
   localparam int IB = pps_pkg::ID_BITS;

   logic completed;
   assign completed = (rsp_tuser == pps_pkg::ST_COMPLETED);

   // a stalled transfer stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // only completions carry times
   a_times_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !completed |-> rsp_tdata[IB+3*TB-1:IB] == '0)
      else $error("times set on a non-completion result");

   // adds and idle ticks carry no job id
   a_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == pps_pkg::ST_ADDED || rsp_tuser == pps_pkg::ST_FULL ||
                     rsp_tuser == pps_pkg::ST_IDLE_TICK)
      |-> rsp_tdata[IB-1:0] == '0)
      else $error("job id on a result without a job");

   // completion ordering: start and turnaround never pass finish
   a_finish_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && completed
      |-> rsp_tdata[IB +: TB] <= rsp_tdata[IB+TB +: TB] &&
          rsp_tdata[IB+2*TB +: TB] <= rsp_tdata[IB+TB +: TB])
      else $error("completion times out of order");

   // reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

   typedef struct packed {
      pps_pkg::status_type status;
      pps_pkg::id_type     id;
      pps_pkg::time_type   started;
      pps_pkg::time_type   finished;
      pps_pkg::time_type   turnaround;
   } outcome_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [pps_pkg::REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                              req_tuser = 1'b0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [pps_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic [pps_pkg::STATUS_BITS-1:0]   rsp_tuser;

   // scheduler shadow state
   logic               slot_busy    [pps_pkg::SLOTS];
   pps_pkg::id_type    slot_job     [pps_pkg::SLOTS];
   pps_pkg::prio_type  slot_prio    [pps_pkg::SLOTS];
   pps_pkg::burst_type slot_left    [pps_pkg::SLOTS];
   pps_pkg::burst_type slot_need    [pps_pkg::SLOTS];
   pps_pkg::time_type  slot_arrived [pps_pkg::SLOTS];
   pps_pkg::time_type  slot_began   [pps_pkg::SLOTS];
   pps_pkg::time_type  clock_now;

   pps_pkg::job_item_type pending_jobs[$];
   outcome_type           expected_outcomes[$];
   pps_pkg::job_item_type on_bus;

   int errors = 0;
   int jobs_sent = 0;
   int results_seen = 0;
   int status_seen[8] = '{default: 0};
   int hold_left = 0;
   logic hold_done = 1'b0;
   int quiet_cycles = 0;

   preemptive_priority_scheduler DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void queue_job(input pps_pkg::job_item_type job);
      pending_jobs.insert(pending_jobs.size(), job);
   endfunction

   function automatic pps_pkg::time_type time_step(input pps_pkg::time_type t);
      return (&t) ? t : pps_pkg::time_type'(t + 1);
   endfunction

   function automatic outcome_type schedule_step(input pps_pkg::job_item_type job);
      outcome_type res;
      int pick;
      logic take;
      res = '0;
      pick = -1;
      if (job.cmd == pps_pkg::CMD_ADD) begin
         res.status = pps_pkg::ST_FULL;
         for (int i = 0; i < pps_pkg::SLOTS; i++) begin
            if (!slot_busy[i] && res.status == pps_pkg::ST_FULL) begin
               slot_busy[i]    = 1'b1;
               slot_job[i]     = job.job_id;
               slot_prio[i]    = job.job_priority;
               slot_need[i]    = job.job_burst;
               slot_left[i]    = job.job_burst;
               slot_arrived[i] = clock_now;
               slot_began[i]   = '0;
               res.status      = pps_pkg::ST_ADDED;
            end
         end
         return res;
      end
      for (int i = 0; i < pps_pkg::SLOTS; i++) begin
         if (slot_busy[i]) begin
            if (pick < 0)
               take = 1'b1;
            else if (slot_prio[i] != slot_prio[pick])
               take = slot_prio[i] < slot_prio[pick];
            else if (slot_arrived[i] != slot_arrived[pick])
               take = slot_arrived[i] < slot_arrived[pick];
            else
               take = slot_job[i] < slot_job[pick];
            if (take)
               pick = i;
         end
      end
      if (pick < 0) begin
         res.status = pps_pkg::ST_IDLE_TICK;
      end else begin
         if (slot_left[pick] == slot_need[pick])
            slot_began[pick] = clock_now;
         res.id = slot_job[pick];
         if (slot_left[pick] <= 1) begin
            slot_left[pick] = '0;
            slot_busy[pick] = 1'b0;
            res.status      = pps_pkg::ST_COMPLETED;
            res.started     = slot_began[pick];
            res.finished    = time_step(clock_now);
            res.turnaround  = res.finished - slot_arrived[pick];
         end else begin
            slot_left[pick] = slot_left[pick] - 1'b1;
            res.status      = pps_pkg::ST_RAN;
         end
      end
      clock_now = time_step(clock_now);
      return res;
   endfunction

   function automatic pps_pkg::job_item_type make_add(input pps_pkg::id_type id,
                                                      input pps_pkg::prio_type prio,
                                                      input pps_pkg::burst_type burst);
      pps_pkg::job_item_type it;
      it.cmd          = pps_pkg::CMD_ADD;
      it.job_id       = id;
      it.job_priority = prio;
      it.job_burst    = burst;
      return it;
   endfunction

   // fields are don't-care on a tick, so fill them with noise
   function automatic pps_pkg::job_item_type make_tick();
      pps_pkg::job_item_type it;
      it.cmd          = pps_pkg::CMD_TICK;
      it.job_id       = pps_pkg::id_type'($urandom);
      it.job_priority = pps_pkg::prio_type'($urandom);
      it.job_burst    = pps_pkg::burst_type'($urandom);
      return it;
   endfunction

   task automatic check_field(input string label, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_outcomes.insert(expected_outcomes.size(), schedule_step(on_bus));
            jobs_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_jobs.size() > 0 &&
                ((jobs_sent >= 800 && jobs_sent < 1300) || $urandom_range(0, 99) >= 28)) begin
               on_bus = pending_jobs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= pps_pkg::REQ_DATA_BITS'({on_bus.job_burst,
                                                      on_bus.job_priority,
                                                      on_bus.job_id});
               req_tuser  <= on_bus.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and result-side flow control
   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            status_seen[rsp_tuser]++;
            if (expected_outcomes.size() == 0) begin
               errors++;
               $display("%0t: unexpected transfer, expected none, got status %0d data %h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               want = expected_outcomes.pop_front();
               check_field("status", 16'(want.status), 16'(rsp_tuser));
               check_field("done_id", 16'(want.id), 16'(rsp_tdata[7:0]));
               check_field("start_time", want.started, rsp_tdata[23:8]);
               check_field("finish_time", want.finished, rsp_tdata[39:24]);
               check_field("turnaround", want.turnaround, rsp_tdata[55:40]);
            end
         end
         // long hold-off backs the block up into its input
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && results_seen >= 400) begin
            hold_done = 1'b1;
            hold_left = 300;
            rsp_tready <= 1'b0;
         end else if (results_seen >= 800 && results_seen < 1300) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 28);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= 2000) begin
         $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
         $display("testbench NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int randoms;
      int n;
      int r;
      pps_pkg::prio_type prio;
      pps_pkg::burst_type burst;
      foreach (slot_busy[i])
         slot_busy[i] = 1'b0;
      clock_now = '0;

      // idle tick, zero burst, priority ties, duplicate ids, full table
      queue_job(make_tick());
      queue_job(make_add(8'hFF, 8'hFF, 16'd0));
      queue_job(make_add(8'd9, 8'd0, 16'd2));
      queue_job(make_add(8'd3, 8'd0, 16'd1));
      queue_job(make_add(8'd3, 8'd0, 16'd2));
      repeat (7)
         queue_job(make_tick());
      for (int i = 0; i < pps_pkg::SLOTS + 1; i++)
         queue_job(make_add(pps_pkg::id_type'(i * 15),
                            pps_pkg::prio_type'($urandom_range(0, 2)),
                            pps_pkg::burst_type'($urandom_range(0, 4))));

      randoms = 0;
      while (randoms < 2000) begin
         n = $urandom_range(1, 8);
         repeat (n) begin
            r = $urandom_range(0, 999);
            prio = ($urandom_range(0, 1) == 0) ? pps_pkg::prio_type'($urandom_range(0, 3))
                                               : pps_pkg::prio_type'($urandom_range(0, 254));
            if (r < 3) begin
               burst = pps_pkg::burst_type'($urandom);
               prio  = 8'hFF;
            end else if (r < 40) begin
               burst = pps_pkg::burst_type'($urandom_range(0, 100));
            end else begin
               burst = pps_pkg::burst_type'($urandom_range(0, 6));
            end
            queue_job(make_add(($urandom_range(0, 1) == 0)
                               ? pps_pkg::id_type'($urandom_range(0, 3))
                               : pps_pkg::id_type'($urandom), prio, burst));
         end
         randoms += n;
         n = $urandom_range(1, 40);
         repeat (n)
            queue_job(make_tick());
         randoms += n;
      end

      // maximal job parked in the table, then short jobs that preempt it
      queue_job(make_add(8'hA5, 8'hFE, 16'hFFFF));
      queue_job(make_add(8'h5A, 8'd0, 16'd0));
      queue_job(make_add(8'hC3, 8'd0, 16'd3));
      queue_job(make_add(8'h3C, 8'd0, 16'd1));
      repeat (6)
         queue_job(make_tick());

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      do
         @(negedge clock);
      while (pending_jobs.size() > 0 || req_tvalid || expected_outcomes.size() > 0);
      repeat (40) @(posedge clock);

      $display("Sent %0d transfers: %0d jobs placed, %0d turned away by a full table.",
               jobs_sent, status_seen[pps_pkg::ST_ADDED], status_seen[pps_pkg::ST_FULL]);
      $display("Ticks: %0d idle, %0d ran, %0d completions; time ended at %0d.",
               status_seen[pps_pkg::ST_IDLE_TICK], status_seen[pps_pkg::ST_RAN],
               status_seen[pps_pkg::ST_COMPLETED], clock_now);
      if (errors == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
